// ----- hw/rtl/cfr_pkg.sv -----
// cfr_pkg: shared constants and types of the command frame receiver.
// Holds the default coordinate size, the register map and the register struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

	// Default number of bytes per coordinate (legal range 1..4)
	localparam int CFR_COORD_BYTES = 2;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_WORD    = 3'd0,
		REG_ACK_CODE       = 3'd1,
		REG_NACK_CODE      = 3'd2,
		REG_STATUS_QUERY   = 3'd3,
		REG_SET_ACTIVE     = 3'd4,
		REG_CLEAR_ACTIVE   = 3'd5,
		REG_ACTIVE_VALUE   = 3'd6,
		REG_INACTIVE_VALUE = 3'd7
	} cfr_reg_t;

	// Register file contents as seen by the frame logic
	typedef struct packed {
		logic [15:0] header_word;
		logic [7:0]  ack_code;
		logic [7:0]  nack_code;
		logic [7:0]  status_query_code;
		logic [7:0]  set_active_code;
		logic [7:0]  clear_active_code;
		logic [7:0]  active_status_value;
		logic [7:0]  inactive_status_value;
	} cfr_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/command_frame_receiver.sv -----
// command_frame_receiver: byte-serial header/command/target frame receiver.
// Output: each result is registered and presented in the cycle after its input byte transfer.
// Throughput: one byte per cycle while in_stall is low; the single state update per byte
// sits between the state registers and the output register.
// Reset: phase idle, byte counter at COORD_BYTES, status and all codes zero;
// the frame byte store is not cleared and is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver
	import cfr_pkg::*;
#(
	parameter int COORD_BYTES = CFR_COORD_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// received bytes
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	// results
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       tx_valid,
	output logic [7:0]                 tx_byte,
	output logic                       target_valid,
	output logic [15:0]                target_x,
	output logic [15:0]                target_y,
	output logic [15:0]                target_z,
	output logic                       rotation_valid,
	output logic signed [7:0]          rotation,
	output logic [7:0]                 status_byte
);

	// Frame store geometry: three coordinates of COORD_BYTES bytes each
	localparam int FRAME_LEN = 3 * COORD_BYTES;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam int BL_W      = $clog2(COORD_BYTES + 1);
	// Only the low 16 bits of a coordinate are delivered
	localparam int OUT_BYTES = (COORD_BYTES < 2) ? COORD_BYTES : 2;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_HDR_LO = 7'b0000010,
		PH_CMD    = 7'b0000100,
		PH_X      = 7'b0001000,
		PH_Y      = 7'b0010000,
		PH_Z      = 7'b0100000,
		PH_ROT    = 7'b1000000
	} cfr_phase_t;

	cfr_cfg_t cfg;

	cfr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---------------------------------------------------------------------
	// Handshake: the output register parts the two sides. Stall the input
	// only while a result sits in the output register and is itself stalled.
	// ---------------------------------------------------------------------
	logic in_acc;
	logic out_valid_q;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// ---------------------------------------------------------------------
	// State registers
	// ---------------------------------------------------------------------
	cfr_phase_t       phase_q, phase_n;
	logic [BL_W-1:0]  bytes_left_q, bytes_left_n;
	logic [IDX_W-1:0] write_index_q, write_index_n;
	logic [7:0]       status_q, status_n;
	logic [7:0]       frame_q [FRAME_LEN];

	// Per-byte outcome
	logic             coord_step;
	logic             frame_we;
	logic             tx_v, tgt_v, rot_v;
	logic [7:0]       tx_b;
	logic [7:0]       frame_nx [FRAME_LEN];
	logic [15:0]      coord [3];

	always_comb begin
		phase_n       = phase_q;
		bytes_left_n  = bytes_left_q;
		write_index_n = write_index_q;
		status_n      = status_q;
		coord_step    = 1'b0;
		frame_we      = 1'b0;
		tx_v          = 1'b0;
		tx_b          = '0;
		tgt_v         = 1'b0;
		rot_v         = 1'b0;

		unique case (phase_q)
			PH_HDR_LO: begin
				// Mismatch on the low byte keeps waiting for the low byte
				if (rx_byte == cfg.header_word[7:0]) begin
					phase_n = PH_CMD;
				end else begin
					tx_v = 1'b1;
					tx_b = cfg.nack_code;
				end
			end
			PH_CMD: begin
				// Priority: status query, then set, then clear
				if (rx_byte == cfg.status_query_code) begin
					tx_v = 1'b1;
					tx_b = status_q;
				end else if (rx_byte == cfg.set_active_code) begin
					status_n = cfg.active_status_value;
				end else if (rx_byte == cfg.clear_active_code) begin
					status_n = cfg.inactive_status_value;
				end else begin
					// Not a command: this byte opens the target frame as x
					phase_n    = PH_X;
					coord_step = 1'b1;
				end
			end
			PH_X, PH_Y, PH_Z: begin
				coord_step = 1'b1;
			end
			PH_ROT: begin
				rot_v   = 1'b1;
				phase_n = PH_IDLE;
			end
			PH_IDLE: begin
				if (rx_byte == cfg.header_word[15:8]) begin
					phase_n = PH_HDR_LO;
				end else begin
					tx_v = 1'b1;
					tx_b = cfg.nack_code;
				end
			end
			default: begin
				// Unknown phase code behaves as idle
				phase_n = PH_IDLE;
				if (rx_byte == cfg.header_word[15:8]) begin
					phase_n = PH_HDR_LO;
				end else begin
					tx_v = 1'b1;
					tx_b = cfg.nack_code;
				end
			end
		endcase

		// Coordinate byte: store, count down, ack on the last byte
		if (coord_step) begin
			frame_we      = 1'b1;
			write_index_n = write_index_q + IDX_W'(1);
			bytes_left_n  = bytes_left_q - BL_W'(1);
			if (bytes_left_q == BL_W'(1)) begin
				bytes_left_n = BL_W'(COORD_BYTES);
				tx_v         = 1'b1;
				tx_b         = cfg.ack_code;
				if (phase_q == PH_Z) begin
					write_index_n = '0;
					tgt_v         = 1'b1;
					phase_n       = PH_ROT;
				end else if (phase_q == PH_Y) begin
					phase_n = PH_Z;
				end else begin
					// x done, whether entered from the command phase or not
					phase_n = PH_Y;
				end
			end
		end
	end

	// Frame bytes as they stand after this byte, so the last z byte is seen
	always_comb begin
		for (int i = 0; i < FRAME_LEN; i++) begin
			frame_nx[i] = (frame_we && (write_index_q == IDX_W'(i))) ? rx_byte : frame_q[i];
		end
	end

	// Little-endian assembly, low 16 bits only
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			coord[c] = '0;
			for (int k = 0; k < OUT_BYTES; k++) begin
				coord[c][8*k +: 8] = frame_nx[c*COORD_BYTES + k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bytes_left_q  <= BL_W'(COORD_BYTES);
			write_index_q <= '0;
			status_q      <= '0;
		end else if (in_acc) begin
			phase_q       <= phase_n;
			bytes_left_q  <= bytes_left_n;
			write_index_q <= write_index_n;
			status_q      <= status_n;
		end
	end

	// Frame store: one write port, no reset
	always_ff @(posedge clk) begin
		if (in_acc && frame_we) begin
			frame_q[write_index_q] <= rx_byte;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: load on an input transfer, drop once taken
	// ---------------------------------------------------------------------
	logic              tx_valid_q;
	logic [7:0]        tx_byte_q;
	logic              target_valid_q;
	logic [15:0]       target_x_q, target_y_q, target_z_q;
	logic              rotation_valid_q;
	logic signed [7:0] rotation_q;
	logic [7:0]        status_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tx_valid_q       <= tx_v;
			tx_byte_q        <= tx_b;
			target_valid_q   <= tgt_v;
			target_x_q       <= tgt_v ? coord[0] : 16'd0;
			target_y_q       <= tgt_v ? coord[1] : 16'd0;
			target_z_q       <= tgt_v ? coord[2] : 16'd0;
			rotation_valid_q <= rot_v;
			rotation_q       <= rot_v ? $signed(rx_byte) : 8'sd0;
			status_byte_q    <= status_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign tx_valid       = tx_valid_q;
	assign tx_byte        = tx_byte_q;
	assign target_valid   = target_valid_q;
	assign target_x       = target_x_q;
	assign target_y       = target_y_q;
	assign target_z       = target_z_q;
	assign rotation_valid = rotation_valid_q;
	assign rotation       = rotation_q;
	assign status_byte    = status_byte_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// A delivered triple always comes with the ack of its last coordinate
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && target_valid_q) |-> (tx_valid_q && tx_byte_q == cfg.ack_code))
		else $error("target delivered without ack");

	// Triple and rotation belong to different bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(target_valid_q && rotation_valid_q))
		else $error("target and rotation in one result");

	// Completing the triple rewinds the frame store and waits for rotation
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && tgt_v) |=> (write_index_q == '0 && phase_q == PH_ROT))
		else $error("frame not rewound after triple");

	// The rotation byte returns the block to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_ROT) |=> (phase_q == PH_IDLE && rotation_valid_q))
		else $error("rotation byte did not close the frame");

	// The byte counter never rests at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q != '0)
		else $error("coordinate byte counter at zero");

endmodule

`default_nettype wire

// ----- hw/rtl/cfr_cfg_regs.sv -----
// cfr_cfg_regs: configuration register file of the command frame receiver.
// Decodes the write port and holds the code registers; depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_cfg_regs
	import cfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfr_cfg_t                   cfg
);

	cfr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfr_reg_t'(cfg_index))
				REG_HEADER_WORD:    cfg_q.header_word           <= cfg_data;
				REG_ACK_CODE:       cfg_q.ack_code              <= cfg_data[7:0];
				REG_NACK_CODE:      cfg_q.nack_code             <= cfg_data[7:0];
				REG_STATUS_QUERY:   cfg_q.status_query_code     <= cfg_data[7:0];
				REG_SET_ACTIVE:     cfg_q.set_active_code       <= cfg_data[7:0];
				REG_CLEAR_ACTIVE:   cfg_q.clear_active_code     <= cfg_data[7:0];
				REG_ACTIVE_VALUE:   cfg_q.active_status_value   <= cfg_data[7:0];
				REG_INACTIVE_VALUE: cfg_q.inactive_status_value <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire
